// ===== rtl/pat_pkg.sv =====
// Shared constants, codes and slot types for the periodic alarm table.
`default_nettype none

package pat_pkg;

	localparam int SLOTS   = 16;
	localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int TIME_W  = 48;
	localparam int ID_W    = 32;
	localparam int PER_W   = 32;
	localparam int CNT_W   = 16;

	// request kinds (s_tuser)
	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_TICK   = 2'd2;

	// result kinds (m_tuser)
	localparam logic [1:0] KIND_ADDED   = 2'd0;
	localparam logic [1:0] KIND_FULL    = 2'd1;
	localparam logic [1:0] KIND_FIRED   = 2'd2;
	localparam logic [1:0] KIND_REMOVED = 2'd3;

	typedef struct packed {
		logic              valid;
		logic [ID_W-1:0]   id;
		logic [PER_W-1:0]  period;
		logic [CNT_W-1:0]  remaining;
		logic [TIME_W-1:0] due;
	} slot_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		slot_t            data;
	} slot_wr_t;

endpackage

`default_nettype wire

// ===== rtl/pat_slot_store.sv =====
// Slot table: valid bits cleared by reset, slot payload held without reset.
`default_nettype none

module pat_slot_store (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [pat_pkg::IDX_W-1:0] rd_idx,
	output pat_pkg::slot_t               rd,
	input  wire pat_pkg::slot_wr_t       wr
);
	import pat_pkg::*;

	logic [SLOTS-1:0]  valid_q;
	logic [ID_W-1:0]   id_q        [SLOTS];
	logic [PER_W-1:0]  period_q    [SLOTS];
	logic [CNT_W-1:0]  remaining_q [SLOTS];
	logic [TIME_W-1:0] due_q       [SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.idx] <= wr.data.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			id_q[wr.idx]        <= wr.data.id;
			period_q[wr.idx]    <= wr.data.period;
			remaining_q[wr.idx] <= wr.data.remaining;
			due_q[wr.idx]       <= wr.data.due;
		end
	end

	always_comb begin
		rd.valid     = valid_q[rd_idx];
		rd.id        = id_q[rd_idx];
		rd.period    = period_q[rd_idx];
		rd.remaining = remaining_q[rd_idx];
		rd.due       = due_q[rd_idx];
	end

endmodule

`default_nettype wire

// ===== rtl/periodic_alarm_table_top.sv =====
// Periodic alarm table: request sequencer, shared adder/comparators and result register.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tuser = action, s_tdata = now/period/count/fire_now/id
// m_*       out  m_tvalid/m_tready  m_tuser = kind, m_tdata = alarm_id, m_tlast = last
//
// Add: accept, one read per slot, write and report. Remove: accept, one read per slot (clearing
// a hit), report; a zero target id ends unreported. Tick: accept, due pass, then per fired alarm
// a minimum scan and a firing. One slot read port and one shared 48-bit adder set this order.
// s_tready is high only in idle; the last result may still wait in the output register.
// A stalled m_tready holds the sequencer at its reporting step.
// Reset clears the valid bits, newest id and control state at once; no clearing pass.
`default_nettype none

module periodic_alarm_table_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [135:0] s_tdata,  // now_us[47:0], period_us[79:48], repeat_count[95:80],
	                                    // fire_now[96], target_id[128:97], zero pad[135:129]
	input  wire logic [1:0]   s_tuser,  // action[1:0]
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [31:0]       m_tdata,  // alarm_id[31:0]
	output logic [1:0]        m_tuser,  // kind[1:0]
	output logic              m_tlast   // last
);
	import pat_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE      = 8'b0000_0001,
		ST_ADD_SCAN  = 8'b0000_0010,
		ST_ADD_WRITE = 8'b0000_0100,
		ST_REM_SCAN  = 8'b0000_1000,
		ST_REM_DONE  = 8'b0001_0000,
		ST_DUE_SCAN  = 8'b0010_0000,
		ST_MIN_SCAN  = 8'b0100_0000,
		ST_FIRE      = 8'b1000_0000
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  idx_q;
	logic              idx_last;

	// captured request
	logic [TIME_W-1:0] now_q;
	logic [PER_W-1:0]  period_q;
	logic [CNT_W-1:0]  count_q;
	logic              fire_now_q;
	logic [ID_W-1:0]   target_q;

	logic [ID_W-1:0]   newest_id_q;
	logic [ID_W-1:0]   fresh_id;

	// add search results
	logic              match_q;
	logic [IDX_W-1:0]  match_idx_q;
	logic              free_found_q;
	logic [IDX_W-1:0]  free_idx_q;

	// tick bookkeeping
	logic [SLOTS-1:0]  pending_q;
	logic [SLOTS-1:0]  pending_clr;
	logic              best_found_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [ID_W-1:0]   best_id_q;

	// slot store access
	logic [IDX_W-1:0]  rd_idx;
	slot_t             rd;
	slot_wr_t          wr;

	// shared arithmetic
	logic [PER_W-1:0]  addend;
	logic [TIME_W-1:0] sum;
	logic              due_hit;
	logic              id_hit;
	logic              min_take;

	// result register
	logic              m_tvalid_q;
	logic [ID_W-1:0]   out_id_q;
	logic [1:0]        out_kind_q;
	logic              out_last_q;
	logic              emit_ok;
	logic              emit_en;
	logic [1:0]        emit_kind;
	logic [ID_W-1:0]   emit_id;
	logic              emit_last;

	logic              s_accept;

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_id_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign emit_ok  = !m_tvalid_q || m_tready;
	assign idx_last = (idx_q == IDX_W'(SLOTS - 1));

	pat_slot_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (rd_idx),
		.rd     (rd),
		.wr     (wr)
	);

	always_comb begin
		fresh_id = newest_id_q + 1'b1;
		if (fresh_id == '0) begin
			fresh_id = {{(ID_W-1){1'b0}}, 1'b1};
		end
		rd_idx   = (state_q == ST_FIRE) ? best_idx_q : idx_q;
		// one adder: add uses the request's period (zero with fire_now), a firing the slot's own
		addend   = (state_q == ST_FIRE) ? rd.period : (fire_now_q ? '0 : period_q);
		sum      = now_q + {{(TIME_W-PER_W){1'b0}}, addend};
		due_hit  = rd.valid && (now_q >= rd.due);
		id_hit   = rd.valid && (rd.id == ((state_q == ST_ADD_SCAN) ? fresh_id : target_q));
		min_take = pending_q[idx_q] && (!best_found_q || (rd.id < best_id_q));
		pending_clr = pending_q;
		pending_clr[best_idx_q] = 1'b0;
	end

	// slot writes and result generation
	always_comb begin
		wr.en     = 1'b0;
		wr.idx    = rd_idx;
		wr.data   = rd;
		emit_en   = 1'b0;
		emit_kind = KIND_ADDED;
		emit_id   = fresh_id;
		emit_last = 1'b1;
		unique case (state_q)
			ST_ADD_WRITE: begin
				if (emit_ok) begin
					emit_en = 1'b1;
					if (match_q || free_found_q) begin
						wr.en             = 1'b1;
						wr.idx            = match_q ? match_idx_q : free_idx_q;
						wr.data.valid     = 1'b1;
						wr.data.id        = fresh_id;
						wr.data.period    = period_q;
						wr.data.remaining = count_q;
						wr.data.due       = sum;
					end else begin
						emit_kind = KIND_FULL;
						emit_id   = '0;
					end
				end
			end
			ST_REM_SCAN: begin
				if (id_hit) begin
					wr.en         = 1'b1;
					wr.data.valid = 1'b0;
				end
			end
			ST_REM_DONE: begin
				emit_en   = emit_ok;
				emit_kind = KIND_REMOVED;
				emit_id   = target_q;
			end
			ST_FIRE: begin
				if (emit_ok) begin
					wr.en       = 1'b1;
					wr.data.due = sum;
					// a finite count runs down and frees the slot on its final firing
					if (rd.remaining != '0) begin
						wr.data.remaining = rd.remaining - 1'b1;
						if (rd.remaining == {{(CNT_W-1){1'b0}}, 1'b1}) begin
							wr.data.valid = 1'b0;
						end
					end
					emit_en   = 1'b1;
					emit_kind = KIND_FIRED;
					emit_id   = best_id_q;
					emit_last = (pending_clr == '0);
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			newest_id_q  <= '0;
			pending_q    <= '0;
			match_q      <= 1'b0;
			match_idx_q  <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			best_found_q <= 1'b0;
			best_idx_q   <= '0;
			best_id_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						idx_q        <= '0;
						match_q      <= 1'b0;
						free_found_q <= 1'b0;
						unique case (s_tuser)
							ACT_ADD:    state_q <= ST_ADD_SCAN;
							ACT_REMOVE: state_q <= (s_tdata[128:97] != '0) ? ST_REM_SCAN : ST_IDLE;
							ACT_TICK:   state_q <= ST_DUE_SCAN;
							default:    state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ADD_SCAN: begin
					// an id still in use after wrap wins over the first free slot
					if (id_hit && !match_q) begin
						match_q     <= 1'b1;
						match_idx_q <= idx_q;
					end
					if (!rd.valid && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= idx_q;
					end
					idx_q <= idx_last ? '0 : idx_q + 1'b1;
					if (idx_last) begin
						state_q <= ST_ADD_WRITE;
					end
				end
				ST_ADD_WRITE: begin
					if (emit_ok) begin
						if (match_q || free_found_q) begin
							newest_id_q <= fresh_id;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_REM_SCAN: begin
					idx_q <= idx_last ? '0 : idx_q + 1'b1;
					if (idx_last) begin
						state_q <= ST_REM_DONE;
					end
				end
				ST_REM_DONE: begin
					if (emit_ok) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DUE_SCAN: begin
					// due set is fixed by the tick's time before any firing
					pending_q[idx_q] <= due_hit;
					idx_q <= idx_last ? '0 : idx_q + 1'b1;
					if (idx_last) begin
						best_found_q <= 1'b0;
						state_q      <= ((pending_q != '0) || due_hit) ? ST_MIN_SCAN : ST_IDLE;
					end
				end
				ST_MIN_SCAN: begin
					if (min_take) begin
						best_found_q <= 1'b1;
						best_idx_q   <= idx_q;
						best_id_q    <= rd.id;
					end
					idx_q <= idx_last ? '0 : idx_q + 1'b1;
					if (idx_last) begin
						state_q <= ST_FIRE;
					end
				end
				ST_FIRE: begin
					if (emit_ok) begin
						pending_q    <= pending_clr;
						best_found_q <= 1'b0;
						state_q      <= (pending_clr != '0) ? ST_MIN_SCAN : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (s_accept) begin
			now_q      <= s_tdata[47:0];
			period_q   <= s_tdata[79:48];
			count_q    <= s_tdata[95:80];
			fire_now_q <= s_tdata[96];
			target_q   <= s_tdata[128:97];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_en) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			out_id_q   <= emit_id;
			out_kind_q <= emit_kind;
			out_last_q <= emit_last;
		end
	end

	// checks
	a_full_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == KIND_FULL)) |-> (m_tdata == '0))
		else $error("table full result carries a non-zero id");

	a_fired_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == KIND_FIRED)) |-> (m_tdata != '0))
		else $error("fired alarm reported with id zero");

	a_pending_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (pending_q == '0))
		else $error("tick left due slots unreported");

	a_newest_only_on_add: assert property (@(posedge clk) disable iff (!arst_n)
		(newest_id_q != $past(newest_id_q)) |-> $past(state_q == ST_ADD_WRITE))
		else $error("newest id moved outside an add");

endmodule

`default_nettype wire
